### design/khp_pkg.sv
package khp_pkg;

    // Request codes carried in the func field.
    localparam logic [2:0] FUNC_TAKE       = 3'd0;
    localparam logic [2:0] FUNC_RELEASE    = 3'd1;
    localparam logic [2:0] FUNC_FREE_OWNER = 3'd2;
    localparam logic [2:0] FUNC_FREE_ALL   = 3'd3;
    localparam logic [2:0] FUNC_SHUTDOWN   = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_GIVE    = 2'd1;
    localparam logic [1:0] KIND_DISPOSE = 2'd2;

    // Which result the datapath builds into its pending register.
    localparam logic [2:0] PEND_MISS       = 3'd0;
    localparam logic [2:0] PEND_TAKE_HIT   = 3'd1;
    localparam logic [2:0] PEND_REL_NONE   = 3'd2;
    localparam logic [2:0] PEND_REL_STORED = 3'd3;
    localparam logic [2:0] PEND_REL_EVICT  = 3'd4;
    localparam logic [2:0] PEND_DISPOSE    = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] owner_key;
        logic [15:0] handle_in;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [15:0] handle_out;
        logic [1:0]  out_kind;
        logic        stored;
        logic        last;
    } res_t;

    typedef struct packed {
        logic       load_in;
        logic       set_ready;
        logic       set_shut;
        logic       idx_clr;
        logic       idx_inc;
        logic       oldest_upd;
        logic       clr_valid;
        logic       wr_slot;
        logic       wr_evict;
        logic       pend_load;
        logic [2:0] pend_sel;
        logic       pend_clr;
        logic       out_load;
        logic       out_last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] in_func;
        logic [2:0] func;
        logic       entry_valid;
        logic       owner_match;
        logic       idx_last;
        logic       out_free;
        logic       pend_valid;
        logic       pool_ready;
        logic       shut_down;
    } sts_t;

endpackage

### design/khp_ctrl.sv
module khp_ctrl import khp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       active;
    logic       freeing;
    logic       match;

    assign s_ready = (state_reg == ST_IDLE);
    assign active  = !sts.shut_down && sts.pool_ready;
    assign freeing = (sts.func == FUNC_FREE_OWNER) || (sts.func == FUNC_FREE_ALL) ||
                     (sts.func == FUNC_SHUTDOWN);
    assign match   = sts.entry_valid &&
                     ((sts.func != FUNC_FREE_OWNER) || sts.owner_match);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.idx_clr = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    case (sts.in_func)
                        FUNC_TAKE: begin
                            if (sts.shut_down) begin
                                cmd.pend_load = 1'b1;
                                cmd.pend_sel  = PEND_MISS;
                                state_next    = ST_FINAL;
                            end else begin
                                cmd.set_ready = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        FUNC_RELEASE: begin
                            if (active) begin
                                state_next = ST_SCAN;
                            end else begin
                                cmd.pend_load = 1'b1;
                                cmd.pend_sel  = PEND_REL_NONE;
                                state_next    = ST_FINAL;
                            end
                        end
                        FUNC_FREE_OWNER, FUNC_FREE_ALL: begin
                            if (active) begin
                                state_next = ST_SCAN;
                            end
                        end
                        FUNC_SHUTDOWN: begin
                            cmd.set_shut = 1'b1;
                            if (active) begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (sts.func == FUNC_TAKE) begin
                    if (sts.entry_valid && sts.owner_match) begin
                        cmd.pend_load = 1'b1;
                        cmd.pend_sel  = PEND_TAKE_HIT;
                        cmd.clr_valid = 1'b1;
                        state_next    = ST_FINAL;
                    end else if (sts.idx_last) begin
                        cmd.pend_load = 1'b1;
                        cmd.pend_sel  = PEND_MISS;
                        state_next    = ST_FINAL;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end else if (sts.func == FUNC_RELEASE) begin
                    if (!sts.entry_valid) begin
                        cmd.pend_load = 1'b1;
                        cmd.pend_sel  = PEND_REL_STORED;
                        cmd.wr_slot   = 1'b1;
                        state_next    = ST_FINAL;
                    end else if (sts.idx_last) begin
                        cmd.pend_load = 1'b1;
                        cmd.pend_sel  = PEND_REL_EVICT;
                        cmd.wr_evict  = 1'b1;
                        state_next    = ST_FINAL;
                    end else begin
                        cmd.oldest_upd = 1'b1;
                        cmd.idx_inc    = 1'b1;
                    end
                end else if (freeing) begin
                    // A found entry waits until the one before it has gone out,
                    // since only the end of the sweep tells which is last.
                    if (!(match && sts.pend_valid && !sts.out_free)) begin
                        if (match) begin
                            cmd.out_load  = sts.pend_valid;
                            cmd.pend_load = 1'b1;
                            cmd.pend_sel  = PEND_DISPOSE;
                            cmd.clr_valid = 1'b1;
                        end
                        if (sts.idx_last) begin
                            state_next = (match || sts.pend_valid) ? ST_FINAL : ST_IDLE;
                        end else begin
                            cmd.idx_inc = 1'b1;
                        end
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINAL: begin
                cmd.idx_clr = 1'b1;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.pend_clr = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/khp_dp.sv
module khp_dp import khp_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data,
    input  cmd_t cmd,
    output sts_t sts
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [31:0] owner_mem  [ENTRIES];
    logic [15:0] handle_mem [ENTRIES];
    logic [31:0] age_mem    [ENTRIES];

    logic [ENTRIES-1:0] entry_valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [31:0]        rd_owner_reg;
    logic [15:0]        rd_handle_reg;
    logic [31:0]        rd_age_reg;

    req_t        in_reg;
    logic [31:0] age_counter_reg;
    logic [31:0] age_stamp;
    logic        pool_ready_reg;
    logic        shut_down_reg;

    logic [IDX_W-1:0] oldest_idx_reg;
    logic [31:0]      oldest_age_reg;
    logic [15:0]      oldest_handle_reg;
    logic             cur_older;
    logic [IDX_W-1:0] evict_idx;
    logic [15:0]      evict_handle;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    res_t pend_reg;
    res_t pend_new;
    logic pend_valid_reg;
    res_t out_word;
    logic m_valid_reg;
    res_t m_data_reg;
    logic out_free;

    always_comb begin
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end else begin
            idx_next = idx_reg;
        end
    end

    assign cur_older    = (idx_reg == '0) || (oldest_age_reg > rd_age_reg);
    assign evict_idx    = cur_older ? idx_reg : oldest_idx_reg;
    assign evict_handle = cur_older ? rd_handle_reg : oldest_handle_reg;
    assign wr_en        = cmd.wr_slot || cmd.wr_evict;
    assign wr_idx       = cmd.wr_slot ? idx_reg : evict_idx;
    assign age_stamp    = age_counter_reg + 32'd1;
    assign out_free     = !m_valid_reg || m_ready;

    always_comb begin
        pend_new = '0;
        case (cmd.pend_sel)
            PEND_TAKE_HIT: begin
                pend_new.found      = 1'b1;
                pend_new.handle_out = rd_handle_reg;
                pend_new.out_kind   = KIND_GIVE;
            end
            PEND_REL_STORED: begin
                pend_new.stored = 1'b1;
            end
            PEND_REL_EVICT: begin
                pend_new.handle_out = evict_handle;
                pend_new.out_kind   = KIND_DISPOSE;
                pend_new.stored     = 1'b1;
            end
            PEND_DISPOSE: begin
                pend_new.handle_out = rd_handle_reg;
                pend_new.out_kind   = KIND_DISPOSE;
            end
            default: begin
                pend_new = '0;
            end
        endcase
    end

    always_comb begin
        out_word      = pend_reg;
        out_word.last = cmd.out_last;
    end

    // Entry store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            owner_mem[wr_idx]  <= in_reg.owner_key;
            handle_mem[wr_idx] <= in_reg.handle_in;
            age_mem[wr_idx]    <= age_stamp;
        end
        rd_owner_reg  <= owner_mem[idx_next];
        rd_handle_reg <= handle_mem[idx_next];
        rd_age_reg    <= age_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            idx_reg         <= '0;
            age_counter_reg <= '0;
            pool_ready_reg  <= 1'b0;
            shut_down_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (cmd.clr_valid) begin
                entry_valid_reg[idx_reg] <= 1'b0;
            end
            if (wr_en) begin
                entry_valid_reg[wr_idx] <= 1'b1;
                age_counter_reg         <= age_stamp;
            end
            if (cmd.set_ready) begin
                pool_ready_reg <= 1'b1;
            end
            if (cmd.set_shut) begin
                shut_down_reg <= 1'b1;
            end
            if (cmd.pend_load) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.pend_clr) begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.oldest_upd && cur_older) begin
            oldest_idx_reg    <= idx_reg;
            oldest_age_reg    <= rd_age_reg;
            oldest_handle_reg <= rd_handle_reg;
        end
        if (cmd.pend_load) begin
            pend_reg <= pend_new;
        end
        if (cmd.out_load) begin
            m_data_reg <= out_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.in_func     = s_data.func;
    assign sts.func        = in_reg.func;
    assign sts.entry_valid = entry_valid_reg[idx_reg];
    assign sts.owner_match = (rd_owner_reg == in_reg.owner_key);
    assign sts.idx_last    = (idx_reg == LAST_IDX);
    assign sts.out_free    = out_free;
    assign sts.pend_valid  = pend_valid_reg;
    assign sts.pool_ready  = pool_ready_reg;
    assign sts.shut_down   = shut_down_reg;

endmodule

### design/keyed_handle_pool_oldest_eviction_unit.sv
// Channel   Ports                       Word     Accepted when
// request   s_valid s_ready s_data      req_t    s_valid and s_ready high at a rising edge
// result    m_valid m_ready m_data      res_t    m_valid and m_ready high at a rising edge
//
// One request is handled at a time, sweeping the entry store one entry per cycle,
// unless a busy output holds the sweep, through its registered read port. The last
// result word is loaded in the final state, and the next request is taken after it.
// Reset is synchronous and clears the valid bits at once; no clearing pass is needed.
// A busy output holds the sweep at each further handle found and at the final word,
// while new requests are taken as soon as the last word of a request waits.
module keyed_handle_pool_oldest_eviction_unit import khp_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    // The controller steps through the sweep and decides, the datapath holds the
    // entry store, the eviction search and the result registers.
    cmd_t cmd;
    sts_t sts;

    khp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Results leave through a single output register, which lets the controller
    // take the next request while the last word of the previous one waits.
    khp_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

### design/khp_chk.sv
module khp_chk import khp_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input res_t m_data
);

    // A stalled result word must not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // A word without a handle carries a zero handle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.out_kind == KIND_NONE) |-> (m_data.handle_out == 16'd0))
        else $error("handle present on an empty result");

    // A successful take gives exactly one word of the give kind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> (m_data.out_kind == KIND_GIVE) && m_data.last
                                    && !m_data.stored)
        else $error("malformed take result");

    // A stored release is always a single word, and is never of the give kind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.stored |-> m_data.last && !m_data.found
                                     && (m_data.out_kind != KIND_GIVE))
        else $error("malformed release result");

endmodule

bind keyed_handle_pool_oldest_eviction_unit khp_chk u_khp_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### bench/tb_keyed_handle_pool_oldest_eviction_unit.sv
`timescale 1ns / 100ps

module tb_keyed_handle_pool_oldest_eviction_unit;
    import khp_pkg::*;

    // The pool size must match the instance below. The predictor keeps its own copy of
    // every entry at this size.
    localparam int POOL_ENTRIES = 8;
    localparam int RESET_CYCLES = 8;

    // These function codes have no meaning. The block must swallow them without a word.
    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

    // The directed table comes in two parts. The opening rows run straight after reset.
    // The closing rows shut the pool down for good, so they can only come after the
    // random requests.
    localparam int OPEN_ROWS   = 20;
    localparam int SCRIPT_ROWS = 25;

    // The number of random requests that do real work. Ignored codes are not counted.
    localparam int RANDOM_ITEMS = 95;
    localparam int HOLD_AT      = 30;   // the receiver starts its long hold-off here
    localparam int PAUSE_AT     = 75;   // the sender waits for an empty pipeline here
    localparam int LONG_HOLD    = 300;  // cycles for which m_ready is held low

    // Waiting this long after the last expected word is enough to catch any stray word.
    localparam int DRAIN_CYCLES = 4 * (POOL_ENTRIES + 2);

    // The longest correct stretch without a handshake is the long hold-off. The limit
    // is several times that.
    localparam int STALL_LIMIT = 2000;

    // One row of the directed table. When typed is set, the answer is written in by
    // hand. Otherwise the predictor supplies the expected words.
    typedef struct packed {
        req_t word;
        logic typed;
        res_t answer;
    } script_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    res_t m_data;

    // Shadow copy of the pool, advanced once for each request that is accepted.
    logic        slot_valid  [POOL_ENTRIES];
    logic [31:0] slot_owner  [POOL_ENTRIES];
    logic [15:0] slot_handle [POOL_ENTRIES];
    logic [31:0] slot_age    [POOL_ENTRIES];
    logic [31:0] age_stamp;
    logic        pool_open;
    logic        pool_shut;

    res_t        step_words[$];  // words caused by the request just accepted
    res_t        words_due[$];   // every result word still outstanding, oldest first

    script_row_t script [SCRIPT_ROWS];

    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned words_checked;
    int unsigned disposals_seen;
    int unsigned ready_gap;
    int unsigned hold_left;
    logic        sender_burst;
    logic        receiver_burst;

    keyed_handle_pool_oldest_eviction_unit #(
        .ENTRIES(POOL_ENTRIES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic script_row_t row(input logic [2:0] func, input logic [31:0] owner,
                                        input logic [15:0] handle);
        script_row_t r;
        r = '0;
        r.word.func = func;
        r.word.owner_key = owner;
        r.word.handle_in = handle;
        return r;
    endfunction

    // Builds a row whose single result word is written in by hand. Such a word is
    // always the last word of its request.
    function automatic script_row_t row_typed(input logic [2:0] func,
                                              input logic [31:0] owner,
                                              input logic [15:0] handle,
                                              input logic found, input logic [15:0] hout,
                                              input logic [1:0] kind, input logic stored);
        script_row_t r;
        r = row(func, owner, handle);
        r.typed = 1'b1;
        r.answer.found = found;
        r.answer.handle_out = hout;
        r.answer.out_kind = kind;
        r.answer.stored = stored;
        r.answer.last = 1'b1;
        return r;
    endfunction

    // Removes valid entries from the shadow pool. It removes every valid entry, or only
    // those of one owner. Each removed handle yields a disposal word, in ascending
    // entry order.
    task automatic dispose_entries(input logic by_owner, input logic [31:0] owner);
        res_t w;
        int   i;
        for (i = 0; i < POOL_ENTRIES; i++) begin
            if (slot_valid[i] && (!by_owner || slot_owner[i] == owner)) begin
                w = '0;
                w.handle_out = slot_handle[i];
                w.out_kind = KIND_DISPOSE;
                step_words.push_back(w);
                slot_valid[i] = 1'b0;
                slot_owner[i] = '0;
                slot_handle[i] = '0;
                slot_age[i] = '0;
            end
        end
    endtask

    // Applies one request to the shadow pool and fills step_words with the words that
    // the request must produce.
    task automatic apply_pool_request(input req_t word);
        res_t w;
        int   i;
        int   slot;
        int   oldest;
        step_words.delete();
        w = '0;
        case (word.func)
            FUNC_TAKE: begin
                // Once the pool is shut down, a take always misses. Otherwise the
                // first take opens the pool. A hit empties the entry but leaves its
                // owner and age in place.
                if (!pool_shut) begin
                    pool_open = 1'b1;
                    for (i = 0; i < POOL_ENTRIES; i++) begin
                        if (w.out_kind == KIND_NONE && slot_valid[i] &&
                            slot_owner[i] == word.owner_key) begin
                            slot_valid[i] = 1'b0;
                            w.found = 1'b1;
                            w.handle_out = slot_handle[i];
                            w.out_kind = KIND_GIVE;
                        end
                    end
                end
                step_words.push_back(w);
            end
            FUNC_RELEASE: begin
                // The handle goes into the first empty entry. When no entry is empty,
                // it replaces the entry with the smallest age. On equal ages the
                // lowest index loses its entry.
                if (!pool_shut && pool_open) begin
                    slot = -1;
                    oldest = 0;
                    for (i = 0; i < POOL_ENTRIES; i++) begin
                        if (slot < 0) begin
                            if (!slot_valid[i])
                                slot = i;
                            else if (slot_age[oldest] > slot_age[i])
                                oldest = i;
                        end
                    end
                    if (slot < 0) begin
                        slot = oldest;
                        w.handle_out = slot_handle[slot];
                        w.out_kind = KIND_DISPOSE;
                    end
                    w.stored = 1'b1;
                    age_stamp = age_stamp + 32'd1;
                    slot_valid[slot] = 1'b1;
                    slot_owner[slot] = word.owner_key;
                    slot_handle[slot] = word.handle_in;
                    slot_age[slot] = age_stamp;
                end
                step_words.push_back(w);
            end
            FUNC_FREE_OWNER: begin
                if (!pool_shut && pool_open)
                    dispose_entries(1'b1, word.owner_key);
            end
            FUNC_FREE_ALL: begin
                if (!pool_shut && pool_open)
                    dispose_entries(1'b0, '0);
            end
            FUNC_SHUTDOWN: begin
                // Only the first shutdown empties the pool. A repeat is silent.
                if (!pool_shut) begin
                    pool_shut = 1'b1;
                    if (pool_open)
                        dispose_entries(1'b0, '0);
                end
            end
            default: begin
            end
        endcase
        if (step_words.size() > 0) begin
            w = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
    endtask

    // Offers one word after a random idle gap, or none, and waits for it to be accepted. On
    // acceptance the word's results are queued, taken from the predictor or from the table.
    // s_valid stays high between requests that have no gap, so it is never lowered
    // and raised in the same time step.
    task automatic send_request(input req_t word, input logic typed, input res_t answer);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= word;
        do @(posedge aclk); while (!(s_valid && s_ready));
        requests_sent++;
        apply_pool_request(word);
        if (typed) begin
            step_words.delete();
            step_words.push_back(answer);
        end
        foreach (step_words[k])
            words_due.push_back(step_words[k]);
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
        end
    endtask

    // The receiver drives m_ready. After each word it waits for the gap that the
    // checker drew, and the long hold-off takes priority over that gap.
    initial begin : result_ready_driver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every result word that is accepted is checked against the oldest word still due.
    always @(posedge aclk) begin : result_check
        res_t due;
        if (aresetn && m_valid && m_ready) begin
            words_checked++;
            if (m_data.out_kind == KIND_DISPOSE)
                disposals_seen++;
            if (words_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: result word %h arrived with nothing outstanding",
                         $time, m_data);
            end else begin
                due = words_due.pop_front();
                compare_field("found", 16'(due.found), 16'(m_data.found));
                compare_field("handle_out", due.handle_out, m_data.handle_out);
                compare_field("out_kind", 16'(due.out_kind), 16'(m_data.out_kind));
                compare_field("stored", 16'(due.stored), 16'(m_data.stored));
                compare_field("last", 16'(due.last), 16'(m_data.last));
            end
            if ($urandom_range(0, 15) == 0)
                receiver_burst = !receiver_burst;
            ready_gap = receiver_burst ? 0 : $urandom_range(0, 11);
        end
    end

    // The watchdog ends the run when no word has moved on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no word moved for %0d cycles, %0d words outstanding",
                 $time, STALL_LIMIT, words_due.size());
        $display("** keyed_handle_pool_oldest_eviction_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        req_t        word;
        logic [31:0] owner_keys [4];
        int unsigned useful;
        int unsigned pick;
        logic        hold_done;
        logic        pause_done;
        int          i;

        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        mismatches = 0;
        requests_sent = 0;
        words_checked = 0;
        disposals_seen = 0;
        ready_gap = 0;
        hold_left = 0;
        sender_burst = 1'b0;
        receiver_burst = 1'b0;
        for (i = 0; i < POOL_ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_owner[i] = '0;
            slot_handle[i] = '0;
            slot_age[i] = '0;
        end
        age_stamp = '0;
        pool_open = 1'b0;
        pool_shut = 1'b0;

        // Before the first take, a release is refused and the frees do nothing.
        script[0]  = row_typed(FUNC_RELEASE, 32'h0000_0000, 16'hFFFF,
                               1'b0, 16'h0000, KIND_NONE, 1'b0);
        script[1]  = row(FUNC_FREE_OWNER, 32'h0000_0000, 16'h0000);
        script[2]  = row(FUNC_FREE_ALL, 32'hFFFF_FFFF, 16'hFFFF);
        // The first take misses and opens the pool. A handle of zero is an ordinary
        // handle, and it comes back out on the next take.
        script[3]  = row_typed(FUNC_TAKE, 32'hFFFF_FFFF, 16'h0000,
                               1'b0, 16'h0000, KIND_NONE, 1'b0);
        script[4]  = row_typed(FUNC_RELEASE, 32'hFFFF_FFFF, 16'h0000,
                               1'b0, 16'h0000, KIND_NONE, 1'b1);
        script[5]  = row_typed(FUNC_TAKE, 32'hFFFF_FFFF, 16'hFFFF,
                               1'b1, 16'h0000, KIND_GIVE, 1'b0);
        // Eight releases fill the pool. The ninth evicts the oldest entry.
        script[6]  = row(FUNC_RELEASE, 32'h0000_0000, 16'hFFFF);
        script[7]  = row(FUNC_RELEASE, 32'hFFFF_FFFF, 16'h0001);
        script[8]  = row(FUNC_RELEASE, 32'h0000_0000, 16'h8000);
        script[9]  = row(FUNC_RELEASE, 32'h8000_0001, 16'h7FFF);
        script[10] = row(FUNC_RELEASE, 32'hFFFF_FFFF, 16'h0000);
        script[11] = row(FUNC_RELEASE, 32'h0000_0000, 16'hAAAA);
        script[12] = row(FUNC_RELEASE, 32'h7FFF_FFFE, 16'h5555);
        script[13] = row(FUNC_RELEASE, 32'hFFFF_FFFF, 16'h1234);
        script[14] = row(FUNC_RELEASE, 32'hA5A5_5A5A, 16'hBEEF);
        script[15] = row(FUNC_TAKE, 32'h0000_0000, 16'h0000);
        script[16] = row(FUNC_UNUSED_HI, 32'hFFFF_FFFF, 16'hFFFF);
        script[17] = row(FUNC_FREE_OWNER, 32'hFFFF_FFFF, 16'h0000);
        script[18] = row(FUNC_FREE_ALL, 32'h0000_0000, 16'h0000);
        script[19] = row(FUNC_RELEASE, 32'h1234_5678, 16'h0F0F);
        // Shutdown empties the pool once. After that, every request meets a dead pool.
        script[20] = row(FUNC_SHUTDOWN, 32'h0000_0000, 16'h0000);
        script[21] = row(FUNC_SHUTDOWN, 32'hFFFF_FFFF, 16'hFFFF);
        script[22] = row_typed(FUNC_TAKE, 32'hFFFF_FFFF, 16'h0000,
                               1'b0, 16'h0000, KIND_NONE, 1'b0);
        script[23] = row_typed(FUNC_RELEASE, 32'hFFFF_FFFF, 16'hFFFF,
                               1'b0, 16'h0000, KIND_NONE, 1'b0);
        script[24] = row(FUNC_FREE_OWNER, 32'hFFFF_FFFF, 16'h0000);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < OPEN_ROWS; i++)
            send_request(script[i].word, script[i].typed, script[i].answer);

        // Most owners come from a small set of keys, so takes hit and frees find
        // entries. The rest are fully random, which exercises every key bit.
        owner_keys[0] = 32'h0000_0000;
        owner_keys[1] = 32'hFFFF_FFFF;
        owner_keys[2] = $urandom();
        owner_keys[3] = $urandom();
        useful = 0;
        hold_done = 1'b0;
        pause_done = 1'b0;
        while (useful < RANDOM_ITEMS) begin
            if (!hold_done && useful == HOLD_AT) begin
                // The receiver stops taking words while requests keep coming. The
                // block fills up and must stall its input.
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (!pause_done && useful == PAUSE_AT) begin
                // The word just accepted must not be offered again while the sender
                // waits, so valid drops before the next rising edge.
                @(negedge aclk);
                s_valid <= 1'b0;
                while (words_due.size() != 0) @(posedge aclk);
                pause_done = 1'b1;
            end
            word.owner_key = ($urandom_range(0, 99) < 85) ?
                             owner_keys[$urandom_range(0, 3)] : $urandom();
            word.handle_in = 16'($urandom_range(0, 16'hFFFF));
            pick = $urandom_range(0, 99);
            if (pick < 30)
                word.func = FUNC_TAKE;
            else if (pick < 85)
                word.func = FUNC_RELEASE;
            else if (pick < 92)
                word.func = FUNC_FREE_OWNER;
            else if (pick < 95)
                word.func = FUNC_FREE_ALL;
            else
                word.func = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
            if (word.func < FUNC_UNUSED_LO)
                useful++;
            send_request(word, 1'b0, '0);
        end

        for (i = OPEN_ROWS; i < SCRIPT_ROWS; i++)
            send_request(script[i].word, script[i].typed, script[i].answer);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests (%0d of them from the directed table, the rest random)",
                 requests_sent, SCRIPT_ROWS);
        $display("and checked %0d result words, %0d of them disposals, with %0d mismatches.",
                 words_checked, disposals_seen, mismatches);
        if (mismatches == 0) begin
            $display("** keyed_handle_pool_oldest_eviction_unit: PASSED **");
        end else begin
            $display("** keyed_handle_pool_oldest_eviction_unit: FAILED **");
        end
        $finish;
    end

endmodule
